>>> hw/rtl/line_segment_rasterizer_top_defines.svh
// Assertion macros shared by the line segment rasterizer modules.
`ifndef LINE_SEGMENT_RASTERIZER_TOP_DEFINES_SVH
`define LINE_SEGMENT_RASTERIZER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Clocked check, masked while reset is asserted.
`define LSR_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
// Clocked check that also holds during reset.
`define LSR_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define LSR_ASSERT(lbl, clk, rstn, prop)
`define LSR_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

>>> hw/rtl/lsr_pkg.sv
// Types, constants and helpers for the line segment rasterizer.
package lsr_pkg;

    localparam int CANVAS_SIZE = 64;
    localparam int COORD_W     = 6;
    localparam int CNT_W       = 3;   // counts the divider steps

    localparam logic [COORD_W-1:0] CANVAS_MAX = COORD_W'(CANVAS_SIZE - 1);

    typedef logic [COORD_W-1:0] t_coord;

    typedef struct packed {
        t_coord start_x;
        t_coord start_y;
        t_coord end_x;
        t_coord end_y;
    } t_segment;

    typedef struct packed {
        t_coord pixel_x;
        t_coord pixel_y;
        logic   last_pixel;
    } t_pixel;

    typedef struct packed {
        logic   go;
        t_coord dividend;
        t_coord divisor;
    } t_div_req;

    typedef struct packed {
        logic   done;
        t_coord quot;
        t_coord rem;
    } t_div_rsp;

    // saturate a coordinate onto the canvas
    function automatic t_coord clamp_coord(input t_coord c);
        return (c > CANVAS_MAX) ? CANVAS_MAX : c;
    endfunction

endpackage

>>> hw/rtl/lsr_div.sv
// Restoring divider, one quotient bit per cycle through one subtract/compare.
`include "line_segment_rasterizer_top_defines.svh"
module lsr_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lsr_pkg::t_div_req i_req,
    output lsr_pkg::t_div_rsp o_rsp
);
    import lsr_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    t_coord           r_rem;
    t_coord           r_quo;
    t_coord           r_dvs;

    logic [COORD_W:0] trial;
    logic             ge;
    logic [COORD_W:0] diff;

    assign trial = {r_rem, r_quo[COORD_W-1]};
    assign ge    = (trial >= {1'b0, r_dvs});
    assign diff  = trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(COORD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.go) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
            r_quo <= {r_quo[COORD_W-2:0], ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;
    assign o_rsp.rem  = r_rem;

    `LSR_ASSERT(a_go_starts, i_clk, i_rst_n, i_req.go |=> r_busy)
    `LSR_ASSERT(a_done_idle, i_clk, i_rst_n, r_done |-> !r_busy)
    `LSR_ASSERT(a_rem_below_divisor, i_clk, i_rst_n, r_done |-> (r_rem < r_dvs))

endmodule

>>> hw/rtl/line_segment_rasterizer_top.sv
// Line segment rasterizer: emits the pixels covered by one segment, one per cycle.
// Vertical segment: rows lo to hi-1, first pixel in the cycle after the start word.
// Other segments: |dy| / dx in the divider, then dx+1 pixels, one per cycle.
// busy stays high through the last pixel cycle.
// Results are strobed on o_valid for one cycle each; the receiver cannot stall them.
// Synchronous active-low reset idles the sequencer; the walk registers are not reset.
`include "line_segment_rasterizer_top_defines.svh"
module line_segment_rasterizer_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  lsr_pkg::t_segment i_segment,
    output logic              busy,
    output logic              o_valid,
    output lsr_pkg::t_pixel   o_pixel
);
    import lsr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_RUN  = 3'b100
    } t_state;

    t_state r_state, n_state;

    // walk registers
    logic   r_vert;   // vertical segment: step y only
    logic   r_neg;    // slope is negative
    t_coord r_x;      // current column
    t_coord r_y;      // current row
    t_coord r_end;    // last column, or row bound for a vertical segment
    t_coord r_d;      // dx
    t_coord r_qs;     // whole part of slope, mod 2^COORD_W
    t_coord r_rs;     // fractional part of slope, in units of 1/dx
    t_coord r_r;      // running remainder

    t_coord   xa, ya, xb, yb;
    t_coord   x0, y0, x1, y1;
    t_coord   lo, hi;
    logic     accept;
    logic     swap;
    t_div_req div_req;
    t_div_rsp div_rsp;

    logic [COORD_W:0] rsum;
    logic [COORD_W:0] rdiff;
    logic             carry;
    logic             last;

    assign accept = start && !busy;

    // saturate and order the endpoints
    always_comb begin
        xa   = clamp_coord(i_segment.start_x);
        ya   = clamp_coord(i_segment.start_y);
        xb   = clamp_coord(i_segment.end_x);
        yb   = clamp_coord(i_segment.end_y);
        swap = (xb < xa);
        x0   = swap ? xb : xa;
        y0   = swap ? yb : ya;
        x1   = swap ? xa : xb;
        y1   = swap ? ya : yb;
        lo   = (ya < yb) ? ya : yb;
        hi   = (ya < yb) ? yb : ya;
    end

    // divider gets |dy| / dx the cycle the word is taken
    always_comb begin
        div_req.go       = accept && (xa != xb);
        div_req.dividend = (y1 < y0) ? (y0 - y1) : (y1 - y0);
        div_req.divisor  = x1 - x0;
    end

    lsr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // remainder walk: y advances by qs plus a carry when the fraction wraps
    assign rsum  = {1'b0, r_r} + {1'b0, r_rs};
    assign carry = (rsum >= {1'b0, r_d});
    assign rdiff = rsum - {1'b0, r_d};
    assign last  = r_vert ? (r_y == r_end - COORD_W'(1)) : (r_x == r_end);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (xa != xb)      n_state = S_DIV;
                    else if (lo != hi) n_state = S_RUN;
                end
            end
            S_DIV: begin
                if (div_rsp.done) n_state = S_RUN;
            end
            S_RUN: begin
                if (last) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_vert <= (xa == xb);
            r_neg  <= (y1 < y0);
            r_x    <= (xa == xb) ? xa : x0;
            r_y    <= (xa == xb) ? lo : y0;
            r_end  <= (xa == xb) ? hi : x1;
            r_d    <= x1 - x0;
            r_r    <= '0;
        end else if (r_state == S_DIV && div_rsp.done) begin
            // floor division for a negative slope
            if (!r_neg) begin
                r_qs <= div_rsp.quot;
                r_rs <= div_rsp.rem;
            end else if (div_rsp.rem == '0) begin
                r_qs <= -div_rsp.quot;
                r_rs <= '0;
            end else begin
                r_qs <= ~div_rsp.quot;
                r_rs <= r_d - div_rsp.rem;
            end
        end else if (r_state == S_RUN) begin
            if (r_vert) begin
                r_y <= r_y + COORD_W'(1);
            end else begin
                r_x <= r_x + COORD_W'(1);
                r_y <= r_y + r_qs + {{(COORD_W-1){1'b0}}, carry};
                r_r <= carry ? rdiff[COORD_W-1:0] : rsum[COORD_W-1:0];
            end
        end
    end

    assign busy               = (r_state != S_IDLE);
    assign o_valid            = (r_state == S_RUN);
    assign o_pixel.pixel_x    = r_x;
    assign o_pixel.pixel_y    = r_y;
    assign o_pixel.last_pixel = last;

    `LSR_ASSERT_ALWAYS(a_valid_busy, i_clk, o_valid |-> busy)
    `LSR_ASSERT(a_last_ends, i_clk, i_rst_n, (o_valid && o_pixel.last_pixel) |=> !busy)
    `LSR_ASSERT(a_div_quiet, i_clk, i_rst_n, (r_state == S_DIV) |-> !o_valid)
    `LSR_ASSERT(a_done_in_div, i_clk, i_rst_n, div_rsp.done |-> (r_state == S_DIV))

endmodule
